@@ sv/rnvq_pkg.sv @@
// shared constants and types of the range nearest value query block
`default_nettype none
package rnvq_pkg;

  // table geometry
  localparam int DEPTH  = 1024;
  localparam int ADDR_W = $clog2(DEPTH);

  // field widths
  localparam int IDX_W = 10;
  localparam int VAL_W = 30;

  // request codes
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_SCAN  = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_DONE  = 5'b10000
  } rnvq_state_t;

  // sequencer to distance unit
  typedef struct packed {
    logic             start;
    logic             eval;
    logic [VAL_W-1:0] probe;
  } rnvq_dist_ctl_t;

  // distance unit back to sequencer
  typedef struct packed {
    logic             found;
    logic [VAL_W-1:0] best;
  } rnvq_dist_sts_t;

endpackage
`default_nettype wire

@@ sv/rnvq_if.sv @@
// request and result channel interfaces
`default_nettype none
interface rnvq_req_if;
  import rnvq_pkg::*;
  logic             valid;
  logic             ready;
  logic             req_type;
  logic [IDX_W-1:0] index;
  logic [IDX_W-1:0] range_low;
  logic [IDX_W-1:0] range_high;
  logic [VAL_W-1:0] probe_value;

  modport source (output valid, req_type, index, range_low, range_high, probe_value,
                  input ready);
  modport sink (input valid, req_type, index, range_low, range_high, probe_value,
                output ready);
endinterface

interface rnvq_res_if;
  import rnvq_pkg::*;
  logic             valid;
  logic             ready;
  logic             found;
  logic [VAL_W-1:0] distance;

  modport source (output valid, found, distance, input ready);
  modport sink (input valid, found, distance, output ready);
endinterface
`default_nettype wire

@@ sv/rnvq_ram.sv @@
// generic simple dual port ram with registered read
`default_nettype none
module rnvq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

@@ sv/rnvq_dist.sv @@
// shared absolute difference and running minimum unit
`default_nettype none
module rnvq_dist (
  input  logic                        clk,
  input  logic                        rst_n,
  input  rnvq_pkg::rnvq_dist_ctl_t    ctl,
  input  logic [rnvq_pkg::VAL_W-1:0]  rd_data,
  output rnvq_pkg::rnvq_dist_sts_t    sts
);
  import rnvq_pkg::*;

  logic             found_r;
  logic             found_nxt;
  logic [VAL_W-1:0] best_r;
  logic [VAL_W-1:0] best_nxt;
  logic [VAL_W-1:0] probe_r;
  logic [VAL_W:0]   sub;
  logic [VAL_W:0]   neg;
  logic [VAL_W-1:0] diff;

  // one wide subtract, sign picks the magnitude
  assign sub  = {1'b0, rd_data} - {1'b0, probe_r};
  assign neg  = ~sub + 1'b1;
  assign diff = sub[VAL_W] ? neg[VAL_W-1:0] : sub[VAL_W-1:0];

  always_comb begin
    found_nxt = found_r;
    best_nxt  = best_r;
    if (ctl.start) begin
      found_nxt = 1'b0;
      best_nxt  = '0;
    end else if (ctl.eval && (rd_data != '0)) begin
      if (!found_r || (diff < best_r)) begin
        best_nxt = diff;
      end
      found_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
      best_r  <= '0;
    end else begin
      found_r <= found_nxt;
      best_r  <= best_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      probe_r <= ctl.probe;
    end
  end

  assign sts.found = found_r;
  assign sts.best  = best_r;

endmodule
`default_nettype wire

@@ sv/rnvq_ctrl.sv @@
// sequencer: clearing pass, writes, range scan and result register
`default_nettype none
module rnvq_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  rnvq_req_if.sink                     in_req,
  rnvq_res_if.source                   out_res,
  output logic                         ram_we,
  output logic [rnvq_pkg::ADDR_W-1:0]  ram_waddr,
  output logic [rnvq_pkg::VAL_W-1:0]   ram_wdata,
  output logic [rnvq_pkg::ADDR_W-1:0]  ram_raddr,
  output rnvq_pkg::rnvq_dist_ctl_t     dist_ctl,
  input  rnvq_pkg::rnvq_dist_sts_t     dist_sts
);
  import rnvq_pkg::*;

  rnvq_state_t      state_r;
  rnvq_state_t      state_nxt;
  logic [ADDR_W-1:0] addr_r;
  logic [ADDR_W-1:0] addr_nxt;
  logic [ADDR_W-1:0] hi_r;
  logic [ADDR_W-1:0] hi_nxt;
  logic              eval_r;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic              out_found_r;
  logic [VAL_W-1:0]  out_dist_r;
  logic              load_out;
  logic              accept;
  logic              is_query;
  logic              is_write;
  logic [31:0]       hi_clamp;
  logic              range_empty;

  assign in_req.ready = (state_r == ST_IDLE);
  assign accept       = in_req.valid && in_req.ready;
  assign is_query     = accept && (in_req.req_type == REQ_QUERY);
  assign is_write     = accept && (in_req.req_type == REQ_WRITE)
                        && (32'(in_req.index) < 32'(DEPTH));

  // clamp the top of the range to the table, empty when reversed
  assign hi_clamp    = (32'(in_req.range_high) >= 32'(DEPTH)) ? 32'(DEPTH - 1)
                                                               : 32'(in_req.range_high);
  assign range_empty = 32'(in_req.range_low) > hi_clamp;

  // write port: clearing pass or a write item
  assign ram_we    = (state_r == ST_CLEAR) || is_write;
  assign ram_waddr = (state_r == ST_CLEAR) ? addr_r : ADDR_W'(in_req.index);
  assign ram_wdata = (state_r == ST_CLEAR) ? '0 : in_req.probe_value;
  assign ram_raddr = addr_r;

  assign dist_ctl.start = is_query;
  assign dist_ctl.eval  = eval_r;
  assign dist_ctl.probe = in_req.probe_value;

  assign load_out = (state_r == ST_DONE) && (!out_valid_r || out_res.ready);

  always_comb begin
    state_nxt = state_r;
    addr_nxt  = addr_r;
    hi_nxt    = hi_r;
    unique case (state_r)
      ST_CLEAR: begin
        addr_nxt = addr_r + 1'b1;
        if (addr_r == ADDR_W'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (is_query) begin
          if (range_empty) begin
            state_nxt = ST_DONE;
          end else begin
            addr_nxt  = ADDR_W'(in_req.range_low);
            hi_nxt    = ADDR_W'(hi_clamp);
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (addr_r == hi_r) begin
          state_nxt = ST_DRAIN;
        end else begin
          addr_nxt = addr_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (load_out) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_res.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      addr_r      <= '0;
      eval_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      eval_r      <= (state_r == ST_SCAN);
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hi_r <= hi_nxt;
    if (load_out) begin
      out_found_r <= dist_sts.found;
      out_dist_r  <= dist_sts.best;
    end
  end

  assign out_res.valid    = out_valid_r;
  assign out_res.found    = out_found_r;
  assign out_res.distance = out_dist_r;

endmodule
`default_nettype wire

@@ sv/range_nearest_value_query.sv @@
// top level of the range nearest value query block
`default_nettype none
// A table of DEPTH 30-bit values, zero meaning empty. A write item stores its
// probe_value at index (an index past the table is dropped) and gives no result;
// writing zero empties the position and a rewrite replaces the old value. A query
// item scans range_low..range_high (top clamped to the table, reversed range is
// empty) and returns the smallest |entry - probe_value| over nonempty entries,
// with found clear and distance zero when nothing lies in the range.
// Timing: after reset a clearing pass writes zero to every entry, with
// in_req.ready low. A query scans its range one entry at a time: the single
// ram read port delivers one entry per cycle to the shared distance unit, and
// an empty range skips the scan. The result sits in an output register; a
// following write can be taken while it waits, a query finishes its scan and
// then holds until the register is free.
module range_nearest_value_query (
  input  logic       clk,
  input  logic       rst_n,
  rnvq_req_if.sink   in_req,
  rnvq_res_if.source out_res
);
  import rnvq_pkg::*;

  // ram ports
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [VAL_W-1:0]  ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [VAL_W-1:0]  ram_rdata;

  // sequencer to distance unit
  rnvq_dist_ctl_t    dist_ctl;
  rnvq_dist_sts_t    dist_sts;

  // value table, one write and one registered read a cycle
  rnvq_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // shared subtract and compare, keeps the running minimum
  rnvq_dist u_dist (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (dist_ctl),
    .rd_data (ram_rdata),
    .sts     (dist_sts)
  );

  // clearing pass, item handshake, scan addressing and result register
  rnvq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .out_res   (out_res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .dist_ctl  (dist_ctl),
    .dist_sts  (dist_sts)
  );

endmodule
`default_nettype wire
